// File: rtl/seven_segment_scan_controller_defines.svh
`ifndef SEVEN_SEGMENT_SCAN_CONTROLLER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_CONTROLLER_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SSSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sssc check failed");

// next-cycle implication, off while reset is held
`define SSSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sssc check failed");

`endif

// File: rtl/sssc_pkg.sv
`default_nettype none

package sssc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_W     = 2;
    localparam int SLOT_PAD_W = 3;
    localparam int CHAR_W     = 8;
    localparam int SEG_W      = 8;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIGIT_CHARS    = 3'd0,
        REG_DIGIT_MODES    = 3'd1,
        REG_DECIMAL_POINTS = 3'd2,
        REG_COLON_ON       = 3'd3,
        REG_DEGREE_ON      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ON      = 2'd1,
        MODE_BLINK   = 2'd2,
        MODE_OFF_ALT = 2'd3
    } digit_mode_t;

    typedef struct packed {
        logic [31:0] digit_chars;
        logic [7:0]  digit_modes;
        logic [3:0]  decimal_points;
        logic        colon_on;
        logic        degree_on;
    } cfg_regs_t;

    // packed so that the pattern sits in the low bits of tdata
    typedef struct packed {
        logic       degree_drive;
        logic       colon_drive;
        logic [1:0] scan_position;
        logic [3:0] digit_enables;
        logic [7:0] segment_pattern;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/sssc_cfg_regs.sv
`default_nettype none

module sssc_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sssc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sssc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sssc_pkg::cfg_regs_t                   regs
);

    sssc_pkg::cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.digit_chars    <= '0;
            regs_reg.digit_modes    <= 8'h55;
            regs_reg.decimal_points <= '0;
            regs_reg.colon_on       <= 1'b0;
            regs_reg.degree_on      <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (sssc_pkg::cfg_index_t'(cfg_index))
                sssc_pkg::REG_DIGIT_CHARS:    regs_reg.digit_chars    <= cfg_data;
                sssc_pkg::REG_DIGIT_MODES:    regs_reg.digit_modes    <= cfg_data[7:0];
                sssc_pkg::REG_DECIMAL_POINTS: regs_reg.decimal_points <= cfg_data[3:0];
                sssc_pkg::REG_COLON_ON:       regs_reg.colon_on       <= cfg_data[0];
                sssc_pkg::REG_DEGREE_ON:      regs_reg.degree_on      <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/sssc_char_decode.sv
`default_nettype none

module sssc_char_decode (
    input  wire logic [sssc_pkg::CHAR_W-1:0] char_code,
    output logic      [sssc_pkg::SEG_W-1:0]  seg_raw
);

    // active low, a..g in bits 7..1, point dark
    always_comb begin
        unique case (char_code)
            8'h00, 8'h4F: seg_raw = 8'h03;
            8'h01:        seg_raw = 8'h9F;
            8'h02:        seg_raw = 8'h25;
            8'h03:        seg_raw = 8'h0D;
            8'h04:        seg_raw = 8'h99;
            8'h05:        seg_raw = 8'h49;
            8'h06:        seg_raw = 8'h41;
            8'h07:        seg_raw = 8'h1F;
            8'h08:        seg_raw = 8'h01;
            8'h09:        seg_raw = 8'h09;
            8'h41, 8'h52: seg_raw = 8'h11;
            8'h61, 8'h6F: seg_raw = 8'hC5;
            8'h45:        seg_raw = 8'h61;
            8'h66, 8'h46: seg_raw = 8'h71;
            8'h6E:        seg_raw = 8'hD5;
            8'h4E:        seg_raw = 8'h13;
            8'h68:        seg_raw = 8'hD1;
            8'h6C:        seg_raw = 8'hE3;
            8'h72:        seg_raw = 8'hF5;
            8'h75:        seg_raw = 8'hC7;
            default:      seg_raw = sssc_pkg::SEG_BLANK;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/sssc_scan.sv
`default_nettype none

module sssc_scan #(
    parameter int NUM_DIGITS  = 4,
    parameter int BLINK_TICKS = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  wire logic               tick,
    input  wire sssc_pkg::cfg_regs_t cfg,
    output sssc_pkg::result_t       result_next
);

    localparam int DIGIT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CNT_W   = $clog2(2 * BLINK_TICKS + 1);
    localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(NUM_DIGITS - 1);
    localparam logic [CNT_W-1:0]   CNT_LIT    = CNT_W'(BLINK_TICKS);
    localparam logic [CNT_W-1:0]   CNT_CYCLE  = CNT_W'(2 * BLINK_TICKS);

    logic [DIGIT_W-1:0]              digit_reg;
    logic [DIGIT_W-1:0]              digit_next;
    logic [CNT_W-1:0]                count_reg [sssc_pkg::NUM_SLOTS];
    logic [sssc_pkg::SEG_W-1:0]      held_pattern_reg;
    logic [3:0]                      held_enables_reg;
    logic [1:0]                      held_position_reg;

    logic [sssc_pkg::SLOT_PAD_W-1:0] digit_pad;
    logic                            in_range;
    logic [sssc_pkg::SLOT_W-1:0]     slot;
    logic [sssc_pkg::CHAR_W-1:0]     char_code;
    logic [sssc_pkg::SEG_W-1:0]      seg_raw;
    logic [sssc_pkg::SEG_W-1:0]      pattern;
    logic                            point;
    sssc_pkg::digit_mode_t           mode;
    logic [CNT_W-1:0]                cnt;
    logic [CNT_W-1:0]                cnt_next;
    logic                            cnt_we;
    logic                            lit;
    logic [3:0]                      enables;

    // digits past the fourth have no register bits and stay dark
    assign digit_pad = sssc_pkg::SLOT_PAD_W'(digit_reg);
    assign in_range  = ~digit_pad[2];
    assign slot      = digit_pad[1:0];

    assign char_code = in_range ? cfg.digit_chars[slot*8 +: 8] : '0;
    assign point     = in_range & cfg.decimal_points[slot];
    assign mode      = in_range ? sssc_pkg::digit_mode_t'(cfg.digit_modes[slot*2 +: 2])
                                : sssc_pkg::MODE_OFF;

    sssc_char_decode u_decode (
        .char_code (char_code),
        .seg_raw   (seg_raw)
    );

    assign pattern = {seg_raw[7:1], seg_raw[0] & ~point};
    assign cnt     = count_reg[slot];

    always_comb begin
        lit      = 1'b0;
        cnt_we   = 1'b0;
        cnt_next = cnt;
        unique case (mode)
            sssc_pkg::MODE_ON: begin
                lit = 1'b1;
            end
            sssc_pkg::MODE_BLINK: begin
                cnt_we = 1'b1;
                if (cnt < CNT_CYCLE) begin
                    lit      = (cnt < CNT_LIT);
                    cnt_next = cnt + 1'b1;
                end else begin
                    cnt_next = '0;
                end
            end
            sssc_pkg::MODE_OFF, sssc_pkg::MODE_OFF_ALT: ;
        endcase
    end

    assign enables    = (lit && in_range) ? (4'b0001 << slot) : 4'b0000;
    assign digit_next = (digit_reg == LAST_DIGIT) ? '0 : digit_reg + 1'b1;

    always_comb begin
        result_next.colon_drive  = cfg.colon_on;
        result_next.degree_drive = cfg.degree_on;
        if (tick) begin
            result_next.segment_pattern = pattern;
            result_next.digit_enables   = enables;
            result_next.scan_position   = slot;
        end else begin
            result_next.segment_pattern = held_pattern_reg;
            result_next.digit_enables   = held_enables_reg;
            result_next.scan_position   = held_position_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg         <= '0;
            held_pattern_reg  <= sssc_pkg::SEG_BLANK;
            held_enables_reg  <= '0;
            held_position_reg <= '0;
            for (int i = 0; i < sssc_pkg::NUM_SLOTS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (step_en && tick) begin
            digit_reg         <= digit_next;
            held_pattern_reg  <= pattern;
            held_enables_reg  <= enables;
            held_position_reg <= slot;
            if (cnt_we) begin
                count_reg[slot] <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/seven_segment_scan_controller.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------------
// s_       | in        | s_tvalid / s_tready  | s_tdata[0] refresh_tick
// m_       | out       | m_tvalid / m_tready  | m_tdata pattern, enables, position, colon, degree
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// one item per cycle while the skid stage is empty; the result of a taken item is registered in out_reg
// scan, blink and held state update as each tick item is taken, so items follow back to back
// a stalled result is held in the output register, one more item parks in a skid stage
// aresetn is synchronous, active low; no clearing pass, block is ready right after reset
`default_nettype none

`include "seven_segment_scan_controller_defines.svh"

module seven_segment_scan_controller #(
    parameter int NUM_DIGITS  = 4,
    parameter int BLINK_TICKS = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // [0] refresh_tick
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] segment_pattern, [11:8] digit_enables, [13:12] scan_position,
    // [14] colon_drive, [15] degree_drive
    output logic [15:0]                           m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sssc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sssc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sssc_pkg::cfg_regs_t cfg;
    sssc_pkg::result_t   result_next;
    sssc_pkg::result_t   out_reg;
    sssc_pkg::result_t   skid_reg;
    logic                m_tvalid_reg;
    logic                skid_valid_reg;
    logic                s_accept;
    logic                out_free;

    assign s_tready = ~skid_valid_reg;
    assign s_accept = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    sssc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    sssc_scan #(
        .NUM_DIGITS  (NUM_DIGITS),
        .BLINK_TICKS (BLINK_TICKS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (s_accept),
        .tick        (s_tdata[0]),
        .cfg         (cfg),
        .result_next (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept) begin
                out_reg <= result_next;
            end
        end else if (s_accept) begin
            skid_reg <= result_next;
        end
    end

    `SSSC_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_tvalid_reg)
    `SSSC_ASSERT_NXT(a_stall_parks_item, aclk, aresetn, s_accept && !out_free, skid_valid_reg)
    `SSSC_ASSERT_IMP(a_enables_onehot, aclk, aresetn, m_tvalid_reg,
                     $onehot0(out_reg.digit_enables))
    `SSSC_ASSERT_IMP(a_enable_matches_pos, aclk, aresetn,
                     m_tvalid_reg && (out_reg.digit_enables != 4'b0000),
                     out_reg.digit_enables == (4'b0001 << out_reg.scan_position))

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int NUM_DIGITS  = 4;
    localparam int BLINK_TICKS = 64;
    localparam int PHASE_ITEMS = 190;

    localparam logic [7:0] KNOWN_CODES [24] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9,
        "O", "A", "R", "a", "o", "E", "f", "F", "n", "N", "h", "l", "r", "u"
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [7:0]           s_tdata = 8'h00;    // [0] refresh_tick
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    sssc_pkg::cfg_index_t cfg_index = sssc_pkg::REG_DIGIT_CHARS;
    logic [31:0]          cfg_data = 32'h0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic                 cfg_ready;
    // [7:0] segment_pattern, [11:8] digit_enables, [13:12] scan_position,
    // [14] colon_drive, [15] degree_drive
    logic [15:0]          m_tdata;

    // shadow registers and scan state
    logic [31:0]       chars_reg = 32'h0;
    logic [7:0]        modes_reg = 8'h55;
    logic [3:0]        points_reg = 4'h0;
    logic              colon_reg = 1'b0;
    logic              degree_reg = 1'b0;
    logic [1:0]        scan_digit = 2'd0;
    logic [7:0]        blink_cnt [NUM_DIGITS] = '{default: 8'h00};
    sssc_pkg::result_t shown = '{segment_pattern: sssc_pkg::SEG_BLANK, default: '0};

    sssc_pkg::result_t pending_results [$];
    int                src_idle_pct = 0;
    int                sink_idle_pct = 0;
    int                mismatch_count = 0;

    seven_segment_scan_controller #(
        .NUM_DIGITS  (NUM_DIGITS),
        .BLINK_TICKS (BLINK_TICKS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] seg_pattern_of(input logic [7:0] code);
        case (code)
            8'd0, "O": return 8'h03;
            8'd1:      return 8'h9F;
            8'd2:      return 8'h25;
            8'd3:      return 8'h0D;
            8'd4:      return 8'h99;
            8'd5:      return 8'h49;
            8'd6:      return 8'h41;
            8'd7:      return 8'h1F;
            8'd8:      return 8'h01;
            8'd9:      return 8'h09;
            "A", "R":  return 8'h11;
            "a", "o":  return 8'hC5;
            "E":       return 8'h61;
            "f", "F":  return 8'h71;
            "n":       return 8'hD5;
            "N":       return 8'h13;
            "h":       return 8'hD1;
            "l":       return 8'hE3;
            "r":       return 8'hF5;
            "u":       return 8'hC7;
            default:   return sssc_pkg::SEG_BLANK;
        endcase
    endfunction

    function automatic logic [7:0] random_char();
        if ($urandom_range(4) == 0)
            return 8'($urandom_range(255));
        return KNOWN_CODES[$urandom_range(23)];
    endfunction

    task automatic advance_scan(input logic tick);
        logic [7:0]            pat;
        sssc_pkg::digit_mode_t mode;
        logic                  lit;
        if (tick) begin
            pat = seg_pattern_of(chars_reg[8*scan_digit +: 8]);
            if (points_reg[scan_digit])
                pat[0] = 1'b0;
            mode = sssc_pkg::digit_mode_t'(modes_reg[2*scan_digit +: 2]);
            lit = 1'b0;
            if (mode == sssc_pkg::MODE_ON) begin
                lit = 1'b1;
            end else if (mode == sssc_pkg::MODE_BLINK) begin
                if (blink_cnt[scan_digit] < 2 * BLINK_TICKS) begin
                    if (blink_cnt[scan_digit] < BLINK_TICKS)
                        lit = 1'b1;
                    blink_cnt[scan_digit] = blink_cnt[scan_digit] + 8'd1;
                end else begin
                    blink_cnt[scan_digit] = 8'd0;
                end
            end
            shown.segment_pattern = pat;
            shown.digit_enables = lit ? 4'(1 << scan_digit) : 4'h0;
            shown.scan_position = scan_digit;
            scan_digit = (scan_digit == NUM_DIGITS - 1) ? 2'd0 : scan_digit + 2'd1;
        end
        shown.colon_drive = colon_reg;
        shown.degree_drive = degree_reg;
        pending_results.push_back(shown);
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    endtask

    task automatic send_tick(input logic tick);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {7'b0, tick};
        do @(posedge aclk); while (!s_tready);
        advance_scan(tick);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input sssc_pkg::cfg_index_t idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sssc_pkg::REG_DIGIT_CHARS:    chars_reg = val;
            sssc_pkg::REG_DIGIT_MODES:    modes_reg = val[7:0];
            sssc_pkg::REG_DECIMAL_POINTS: points_reg = val[3:0];
            sssc_pkg::REG_COLON_ON:       colon_reg = val[0];
            sssc_pkg::REG_DEGREE_ON:      degree_reg = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [31:0] chars, input logic [7:0] modes,
                             input logic [3:0] points, input logic colon, input logic degree);
        write_reg(sssc_pkg::REG_DIGIT_CHARS, chars);
        write_reg(sssc_pkg::REG_DIGIT_MODES, {24'($urandom), modes});
        write_reg(sssc_pkg::REG_DECIMAL_POINTS, {28'($urandom), points});
        write_reg(sssc_pkg::REG_COLON_ON, {31'($urandom), colon});
        write_reg(sssc_pkg::REG_DEGREE_ON, {31'($urandom), degree});
    endtask

    task automatic test_reset_state();
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    task automatic test_directed_cases();
        wait_idle();
        // known digits, a letter, an unknown code, every mode, points and indicators
        write_all({8'hFF, "A", 8'd9, 8'd0},
                  {sssc_pkg::MODE_OFF_ALT, sssc_pkg::MODE_BLINK,
                   sssc_pkg::MODE_OFF, sssc_pkg::MODE_ON},
                  4'b0101, 1'b1, 1'b1);
        write_reg(sssc_pkg::cfg_index_t'(3'd5), $urandom);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
        write_all(32'hFFFF_FFFF, 8'hFF, 4'hF, 1'b0, 1'b1);
        write_reg(sssc_pkg::cfg_index_t'(3'd7), 32'hFFFF_FFFF);
        repeat (4) send_tick(1'b1);
        wait_idle();
        write_all(32'h0, 8'h00, 4'h0, 1'b1, 1'b0);
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_random_scan(input int src_pct, input int sink_pct);
        logic [31:0] chars;
        logic [7:0]  modes;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        for (int phase = 0; phase < 3; phase++) begin
            wait_idle();
            for (int d = 0; d < NUM_DIGITS; d++) begin
                chars[8*d +: 8] = random_char();
                modes[2*d +: 2] = (phase == 0 || $urandom_range(1))
                                  ? 2'(sssc_pkg::MODE_BLINK)
                                  : 2'($urandom_range(3));
            end
            write_all(chars, modes, 4'($urandom), 1'($urandom), 1'($urandom));
            if ($urandom_range(2) == 0)
                write_reg(sssc_pkg::cfg_index_t'($urandom_range(7, 5)), $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                send_tick($urandom_range(9) != 0);
            end
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn)
            m_tready = ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        sssc_pkg::result_t got;
        sssc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected item", 0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.segment_pattern != want.segment_pattern)
                    note_mismatch("segment_pattern", want.segment_pattern,
                                  got.segment_pattern);
                if (got.digit_enables != want.digit_enables)
                    note_mismatch("digit_enables", want.digit_enables, got.digit_enables);
                if (got.scan_position != want.scan_position)
                    note_mismatch("scan_position", want.scan_position, got.scan_position);
                if (got.colon_drive != want.colon_drive)
                    note_mismatch("colon_drive", want.colon_drive, got.colon_drive);
                if (got.degree_drive != want.degree_drive)
                    note_mismatch("degree_drive", want.degree_drive, got.degree_drive);
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        src_idle_pct = 31;
        sink_idle_pct = 69;
        test_reset_state();
        test_directed_cases();
        test_random_scan(31, 69);
        test_random_scan(69, 31);
        test_random_scan(0, 0);
        wait_idle();
        repeat (4) @(negedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
